/* hdl/cwa_pkg.sv */
// ----------------------------------------------------------------------------
// cwa_pkg
// Shared widths, register indexes, reset values and unit status type for the
// coverage window averager.
// ----------------------------------------------------------------------------
package cwa_pkg;

  // field widths
  localparam int PosW     = 31;
  localparam int DepW     = 16;
  localparam int SegW     = 21;
  localparam int CapW     = 16;
  localparam int RepW     = 31;
  localparam int ValW     = 31;
  localparam int FracW    = 8;
  localparam int SumW     = 37;
  localparam int MeanW    = CapW + FracW;
  localparam int DividendW = SumW + FracW;
  localparam int KW       = 32;

  // stream widths
  localparam int InDataW  = 80;
  localparam int OutDataW = 64;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = SegW;
  localparam logic [CfgIdxW-1:0] REG_SEG_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_COV_CAP = 1'b1;

  localparam logic [SegW-1:0] SEG_RESET = 21'd1024;
  localparam logic [CapW-1:0] CAP_RESET = 16'd250;

  // result kinds
  localparam logic KIND_MEAN   = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* hdl/cwa_div.sv */
// ----------------------------------------------------------------------------
// cwa_div
// Bit-serial restoring divider: one quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
module cwa_div #(
  parameter int DividendW = cwa_pkg::DividendW,
  parameter int DivisorW  = cwa_pkg::SegW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output cwa_pkg::unit_stat_t  stat_o,
  output logic [DividendW-1:0] quot_o,
  output logic [DivisorW-1:0]  rem_o
);
  import cwa_pkg::*;

  localparam int CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;

  // one compare and subtract step
  always_comb begin
    trial  = {rem_q, quo_q[DividendW-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = diff[DivisorW] ? trial[DivisorW-1:0] : diff[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ~diff[DivisorW]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

/* hdl/cwa_mul.sv */
// ----------------------------------------------------------------------------
// cwa_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, lsb first.
// ----------------------------------------------------------------------------
module cwa_mul #(
  parameter int AW = cwa_pkg::SegW,
  parameter int BW = cwa_pkg::DepW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [AW-1:0]       a_i,
  input  logic [BW-1:0]       b_i,
  output cwa_pkg::unit_stat_t stat_o,
  output logic [AW+BW-1:0]    prod_o
);
  import cwa_pkg::*;

  localparam int ProdW = AW + BW;
  localparam int CntW  = $clog2(BW + 1);

  logic [ProdW-1:0] acc_q, acc_d;
  logic [ProdW-1:0] mcand_q, mcand_d;
  logic [BW-1:0]    mplier_q, mplier_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // one add and shift step
  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = ProdW'(a_i);
      mplier_d = b_i;
      cnt_d    = CntW'(BW);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[ProdW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[BW-1:1]};
      cnt_d    = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

/* hdl/coverage_window_averager_top.sv */
// ----------------------------------------------------------------------------
// coverage_window_averager_top
// Bins runs of constant depth into fixed windows and reports capped Q8 means,
// contig headers and repeat counts of identical full windows.
// ----------------------------------------------------------------------------
// Each run uses the bit-serial divider up to three times and the bit-serial
//   multiplier up to two times.
// Throughput: one run at a time; the next run is taken once the previous one
//   has finished, while its last result may still wait in the output register.
// Reset: asynchronous, active low; window state, configuration registers and
//   output valid return to their defaults at once, no clearing pass.
module coverage_window_averager_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [cwa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cwa_pkg::CfgDataW-1:0]   cfg_data_i,
  // run input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cwa_pkg::InDataW-1:0]    s_axis_tdata,  // block_start, block_end, depth
  input  logic                           s_axis_tuser,  // first_of_contig
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cwa_pkg::OutDataW-1:0]   m_axis_tdata,  // value, repeat_res
  output logic                           m_axis_tuser,  // kind
  output logic                           m_axis_tlast   // last
);
  import cwa_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_FIRST      = 4'd1;
  localparam logic [3:0] S_FLUSH_DIV  = 4'd2;
  localparam logic [3:0] S_FLUSH_EMIT = 4'd3;
  localparam logic [3:0] S_HDR_EMIT   = 4'd4;
  localparam logic [3:0] S_WIN        = 4'd5;
  localparam logic [3:0] S_MUL1       = 4'd6;
  localparam logic [3:0] S_KDIV       = 4'd7;
  localparam logic [3:0] S_M1DIV      = 4'd8;
  localparam logic [3:0] S_M1_EMIT    = 4'd9;
  localparam logic [3:0] S_MR_EMIT    = 4'd10;
  localparam logic [3:0] S_TAIL       = 4'd11;
  localparam logic [3:0] S_MUL2       = 4'd12;

  // configuration registers
  logic [SegW-1:0] seg_q;
  logic [CapW-1:0] cap_q;

  // control state
  logic [3:0] state_q, state_d;

  // window state
  logic signed [32:0] ws_q, ws_d;
  logic signed [32:0] ce_q, ce_d;
  logic [SumW-1:0]    psum_q, psum_d;

  // latched run and intermediate results
  logic [PosW-1:0]  start_q, end_q;
  logic [DepW-1:0]  dep_q;
  logic             first_q;
  logic [KW-1:0]    k_q, k_d;
  logic [SegW-1:0]  krem_q, krem_d;
  logic [MeanW-1:0] mean_q, mean_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d;
  logic [ValW-1:0]  out_val_q, out_val_d;
  logic [RepW-1:0]  out_rep_q, out_rep_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  logic             out_load;

  // arithmetic units
  logic                 div_start;
  logic [DividendW-1:0] div_dividend;
  logic [SegW-1:0]      div_divisor;
  unit_stat_t           div_stat;
  logic [DividendW-1:0] div_quot;
  logic [SegW-1:0]      div_rem;
  logic                 mul_start;
  logic [SegW-1:0]      mul_a;
  unit_stat_t           mul_stat;
  logic [SumW-1:0]      mul_prod;

  // derived window quantities
  logic [SegW-1:0]      seg_eff;
  logic signed [32:0]   seg_s, end_s, start_s, rem_s;
  logic signed [32:0]   span, wend, wdiff, tdiff, flen;
  logic                 win;
  logic [DividendW-1:0] cap_x;
  logic [MeanW-1:0]     cap_q8;
  logic [MeanW-1:0]     div_mean;
  logic [DepW-1:0]      dep_cap;
  logic [MeanW-1:0]     mr;
  logic                 k_many;
  logic                 merge;
  logic [KW-1:0]        k_less;

  assign seg_eff = (seg_q == '0) ? SegW'(1) : seg_q;
  assign seg_s   = signed'({12'b0, seg_eff});
  assign end_s   = signed'({2'b00, end_q});
  assign start_s = signed'({2'b00, start_q});
  assign rem_s   = signed'({12'b0, krem_q});
  assign span    = end_s - ws_q + 33'sd1;
  assign win     = seg_s <= span;
  assign wend    = ws_q + seg_s - 33'sd1;
  assign wdiff   = wend - ce_q;
  assign tdiff   = end_s - ce_q;
  assign flen    = ce_q - ws_q + 33'sd1;

  // capped mean from the divider
  assign cap_q8   = {cap_q, 8'h00};
  assign cap_x    = DividendW'(cap_q8);
  assign div_mean = (div_quot < cap_x) ? div_quot[MeanW-1:0] : cap_q8;

  // full windows after the first one carry the run depth
  assign dep_cap = (dep_q < cap_q) ? dep_q : cap_q;
  assign mr      = {dep_cap, 8'h00};
  assign k_many  = k_q > KW'(1);
  assign merge   = k_many && (mr == mean_q) && !k_q[KW-1];
  assign k_less  = k_q - KW'(1);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    ws_d         = ws_q;
    ce_d         = ce_q;
    psum_d       = psum_q;
    k_d          = k_q;
    krem_d       = krem_q;
    mean_d       = mean_q;
    div_start    = 1'b0;
    div_dividend = {psum_q, 8'h00};
    div_divisor  = seg_eff;
    mul_start    = 1'b0;
    mul_a        = tdiff[SegW-1:0];
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_val_d    = out_val_q;
    out_rep_d    = out_rep_q;
    out_last_d   = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (!first_q) begin
          state_d = S_WIN;
        end else if (ws_q <= ce_q) begin
          div_start   = 1'b1;
          div_divisor = flen[SegW-1:0];
          state_d     = S_FLUSH_DIV;
        end else begin
          ws_d    = start_s;
          ce_d    = start_s - 33'sd1;
          psum_d  = '0;
          state_d = S_HDR_EMIT;
        end
      end
      S_FLUSH_DIV: begin
        if (div_stat.done) begin
          mean_d  = div_mean;
          state_d = S_FLUSH_EMIT;
        end
      end
      S_FLUSH_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_MEAN;
          out_val_d  = ValW'(mean_q);
          out_rep_d  = RepW'(1);
          out_last_d = 1'b0;
          ws_d       = start_s;
          ce_d       = start_s - 33'sd1;
          psum_d     = '0;
          state_d    = S_HDR_EMIT;
        end
      end
      S_HDR_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_HEADER;
          out_val_d  = start_q;
          out_rep_d  = '0;
          out_last_d = !win;
          state_d    = S_WIN;
        end
      end
      S_WIN: begin
        if (win) begin
          mul_start = 1'b1;
          mul_a     = (wend > ce_q) ? wdiff[SegW-1:0] : '0;
          state_d   = S_MUL1;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_MUL1: begin
        if (mul_stat.done) begin
          psum_d       = psum_q + mul_prod;
          div_start    = 1'b1;
          div_dividend = DividendW'(span[31:0]);
          state_d      = S_KDIV;
        end
      end
      S_KDIV: begin
        if (div_stat.done) begin
          k_d       = div_quot[KW-1:0];
          krem_d    = div_rem;
          div_start = 1'b1;
          state_d   = S_M1DIV;
        end
      end
      S_M1DIV: begin
        if (div_stat.done) begin
          mean_d  = div_mean;
          state_d = S_M1_EMIT;
        end
      end
      S_M1_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_MEAN;
          out_val_d  = ValW'(mean_q);
          out_rep_d  = merge ? k_q[RepW-1:0] : RepW'(1);
          out_last_d = merge || !k_many;
          ws_d       = end_s + 33'sd1 - rem_s;
          ce_d       = end_s - rem_s;
          psum_d     = '0;
          state_d    = (!merge && k_many) ? S_MR_EMIT : S_TAIL;
        end
      end
      S_MR_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_MEAN;
          out_val_d  = ValW'(mr);
          out_rep_d  = k_less[RepW-1:0];
          out_last_d = 1'b1;
          state_d    = S_TAIL;
        end
      end
      S_TAIL: begin
        if (end_s > ce_q) begin
          mul_start = 1'b1;
          state_d   = S_MUL2;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL2: begin
        if (mul_stat.done) begin
          psum_d  = psum_q + mul_prod;
          ce_d    = end_s;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid follows loads and downstream takes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_q       <= SEG_RESET;
      cap_q       <= CAP_RESET;
      ws_q        <= '0;
      ce_q        <= -33'sd1;
      psum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      ce_q        <= ce_d;
      psum_q      <= psum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SEG_LEN) begin
          seg_q <= cfg_data_i[SegW-1:0];
        end else begin
          cap_q <= cfg_data_i[CapW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      start_q <= s_axis_tdata[PosW-1:0];
      end_q   <= s_axis_tdata[2*PosW-1:PosW];
      dep_q   <= s_axis_tdata[2*PosW+DepW-1:2*PosW];
      first_q <= s_axis_tuser;
    end
    k_q    <= k_d;
    krem_q <= krem_d;
    mean_q <= mean_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_val_q  <= out_val_d;
      out_rep_q  <= out_rep_d;
      out_last_q <= out_last_d;
    end
  end

  // serial arithmetic units
  cwa_div #(
    .DividendW (DividendW),
    .DivisorW  (SegW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  cwa_mul #(
    .AW (SegW),
    .BW (DepW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (dep_q),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rep_q, out_val_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // covered end never falls more than one position behind the window start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ce_q >= ws_q - 33'sd1)
    else $error("covered end behind window start");

  // no division by zero window length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0)
    else $error("division started with zero divisor");

  // units are quiet while a new run may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!div_stat.busy && !mul_stat.busy))
    else $error("arithmetic unit busy in idle");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the coverage window averager. Runs are driven on
// the input stream. A predictor bins each accepted run into windows and
// queues the mean, header and repeat beats it should cause. Every output beat
// is compared field by field with the oldest queued beat. Directed runs cover
// register extremes, contig flushes, merging, overlap and a shrunk window.
// Random contigs follow, with bursts of idling on both sides, one long
// output stall and a final pass without idling.
// ----------------------------------------------------------------------------
module testbench;
  import cwa_pkg::*;

  localparam int          IdleLimit   = 4000;
  localparam int          DrainCycles = 250;
  localparam int          HoldCycles  = 500;
  localparam longint      MaxPos      = 64'h7FFF_FFFF;
  localparam longint      MaxRepeat   = 64'h7FFF_FFFF;

  // one expected result beat
  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] value;
    logic [RepW-1:0] reps;
    logic            last;
  } window_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;   // block_start, block_end, depth
  logic                 s_axis_tuser = 1'b0; // first_of_contig
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [OutDataW-1:0]  m_axis_tdata;        // value, repeat_res
  logic                 m_axis_tuser;        // kind
  logic                 m_axis_tlast;        // last

  // mirrored registers and window state
  logic [SegW-1:0]      seg_len = SEG_RESET;
  logic [CapW-1:0]      cov_cap = CAP_RESET;
  longint               win_start = 0;
  longint               cov_end = -1;
  longint unsigned      win_sum = 0;

  window_result_t       expected_bins[$];
  window_result_t       fresh_beats[4];
  int                   fresh_count;
  int                   fail_count = 0;
  int                   idle_cycles = 0;
  logic                 gaps_on = 1'b1;
  logic                 stalls_on = 1'b1;
  logic                 hold_req = 1'b0;

  coverage_window_averager_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // capped mean in q8
  function automatic longint unsigned capped_q8(input longint unsigned sum,
                                                input longint unsigned len);
    longint unsigned mean;
    longint unsigned ceiling;
    mean = (sum << FracW) / len;
    ceiling = cov_cap;
    ceiling = ceiling << FracW;
    return (mean < ceiling) ? mean : ceiling;
  endfunction

  function automatic void put_beat(input logic kind, input longint unsigned val,
                                   input longint unsigned rep);
    fresh_beats[fresh_count] = '{kind, val[ValW-1:0], rep[RepW-1:0], 1'b0};
    fresh_count++;
  endfunction

  // bin one accepted run and queue the beats it causes
  function automatic void bin_run(input logic [PosW-1:0] first_pos,
                                  input logic [PosW-1:0] last_pos,
                                  input logic [DepW-1:0] dep, input logic opens);
    longint          s;
    longint          e;
    longint          seg;
    longint          span;
    longint          k;
    longint          wend;
    longint          rest;
    longint unsigned m1;
    longint unsigned mr;
    s = first_pos;
    e = last_pos;
    seg = (seg_len == 0) ? 1 : longint'(seg_len);
    fresh_count = 0;

    // new contig: flush the partial window, then the header
    if (opens) begin
      if (win_start <= cov_end)
        put_beat(KIND_MEAN, capped_q8(win_sum, cov_end - win_start + 1), 1);
      put_beat(KIND_HEADER, s, 0);
      win_start = s;
      cov_end = s - 1;
      win_sum = 0;
    end

    // windows closed by this run
    span = e - win_start + 1;
    if (seg <= span) begin
      k = span / seg;
      wend = win_start + seg - 1;
      if (wend > cov_end)
        win_sum += (wend - cov_end) * dep;
      m1 = capped_q8(win_sum, seg);
      rest = k - 1;
      mr = capped_q8(seg * dep, seg);
      if (rest > 0 && mr == m1 && k <= MaxRepeat) begin
        put_beat(KIND_MEAN, m1, k);
      end else begin
        put_beat(KIND_MEAN, m1, 1);
        if (rest > 0)
          put_beat(KIND_MEAN, mr, rest);
      end
      win_start += k * seg;
      if (cov_end < win_start - 1)
        cov_end = win_start - 1;
      win_sum = 0;
      // shrunk window: drop coverage beyond the new window start
      if (cov_end >= win_start)
        cov_end = win_start - 1;
    end

    // remainder goes into the open window
    if (e > cov_end) begin
      win_sum += (e - cov_end) * dep;
      cov_end = e;
    end

    if (fresh_count > 0)
      fresh_beats[fresh_count-1].last = 1'b1;
    for (int i = 0; i < fresh_count; i++)
      expected_bins.push_back(fresh_beats[i]);
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx == REG_SEG_LEN) seg_len = val;
    else cov_cap = val[CapW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // offer one run beat and wait for it to be taken
  task automatic send_run(input logic [PosW-1:0] first_pos, input logic [PosW-1:0] last_pos,
                          input logic [DepW-1:0] dep, input logic opens);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tdata = {2'b00, dep, last_pos, first_pos};
    s_axis_tuser = opens;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    bin_run(first_pos, last_pos, dep, opens);
  endtask

  // stop offering, wait for every expected beat and let the block go quiet
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random contigs: mostly back-to-back runs, some gaps, overlap and noise
  task automatic random_runs(input int count);
    longint          pos;
    longint          len;
    longint          stop;
    longint          span_max;
    logic [DepW-1:0] dep;
    logic            opens;
    int              pick;
    pos = -1;
    dep = $urandom_range(1, 400);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      span_max = (seg_len == 0) ? 2 : 2 * longint'(seg_len);
      // depth often held so that whole windows match
      case ($urandom_range(0, 9))
        0: dep = '0;
        1: dep = '1;
        2, 3, 4: dep = $urandom();
        default: ;
      endcase
      if (pick < 12) begin
        // noise: a run anywhere, sometimes ending before its start
        pos = $urandom_range(0, 32'h7FFF_FFFF);
        stop = (pick < 3) ? pos - $urandom_range(1, 100) : pos + $urandom_range(0, 5000);
        if (stop < 0) stop = 0;
        if (stop > MaxPos) stop = MaxPos;
        opens = $urandom_range(0, 1);
        send_run(pos[PosW-1:0], stop[PosW-1:0], dep, opens);
        pos = (stop >= pos && stop < MaxPos) ? stop + 1 : -1;
      end else begin
        opens = (pos < 0) || ($urandom_range(0, 24) == 0);
        if (opens)
          pos = ($urandom_range(0, 2) == 0) ? longint'($urandom_range(0, 32'h7F00_0000))
                                            : longint'($urandom_range(0, 5000));
        else if (pick < 20)
          pos += $urandom_range(1, 300);
        else if (pick < 24)
          pos -= $urandom_range(1, 40);
        if (pos < 0) pos = 0;
        if (pos > MaxPos) pos = MaxPos;
        case ($urandom_range(0, 9))
          0: len = $urandom_range(0, 1 << 24);
          1, 2: len = $urandom_range(0, 20);
          default: len = $urandom_range(0, span_max);
        endcase
        stop = pos + len;
        if (stop > MaxPos) stop = MaxPos;
        send_run(pos[PosW-1:0], stop[PosW-1:0], dep, opens);
        pos = (stop < MaxPos) ? stop + 1 : -1;
      end
    end
    drain_results();
  endtask

  // reset settings: unmarked first run, capped depth, header for an inverted run
  task automatic test_default_windows();
    send_run(31'd100, 31'd3000, 16'd300, 1'b0);
    send_run(31'd3001, 31'd3500, 16'd0, 1'b0);
    send_run(31'd5000, 31'd4000, 16'd7, 1'b1);
    send_run(31'd5000, 31'd5100, 16'hFFFF, 1'b0);
    drain_results();
  endtask

  // register extremes, zero segment length, repeat count overflow
  task automatic test_extreme_settings();
    write_reg(REG_SEG_LEN, 21'd1);
    write_reg(REG_COV_CAP, 21'hFFFF);
    send_run(31'd0, 31'h7FFF_FFFF, 16'hFFFF, 1'b1);
    drain_results();
    write_reg(REG_SEG_LEN, 21'd0);
    write_reg(REG_COV_CAP, 21'd0);
    send_run(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd1, 1'b1);
    drain_results();
    write_reg(REG_SEG_LEN, 21'h10_0000);
    write_reg(REG_COV_CAP, 21'hFFFF);
    send_run(31'd0, 31'h1F_FFFF, 16'h8000, 1'b1);
    drain_results();
    write_reg(REG_SEG_LEN, 21'h0F_FFFF);
    send_run(31'h7FF0_0000, 31'h7FFF_FFFE, 16'h1234, 1'b1);
    drain_results();
  endtask

  // window shrunk while partly filled
  task automatic test_shrunk_window();
    write_reg(REG_SEG_LEN, 21'd1024);
    write_reg(REG_COV_CAP, 21'd250);
    send_run(31'd0, 31'd599, 16'd10, 1'b1);
    drain_results();
    write_reg(REG_SEG_LEN, 21'd100);
    send_run(31'd0, 31'd150, 16'd5, 1'b0);
    send_run(31'd151, 31'd420, 16'd20, 1'b0);
    drain_results();
  endtask

  // merged and split repeats, overlapping run, gap before a run
  task automatic test_merging_and_overlap();
    write_reg(REG_SEG_LEN, 21'd16);
    send_run(31'd1000, 31'd1079, 16'd3, 1'b1);
    send_run(31'd1080, 31'd1087, 16'd5, 1'b0);
    send_run(31'd1088, 31'd1200, 16'd9, 1'b0);
    send_run(31'd1150, 31'd1203, 16'd200, 1'b0);
    send_run(31'd1300, 31'd1400, 16'd251, 1'b0);
    drain_results();
  endtask

  task automatic test_random_contigs();
    write_reg(REG_SEG_LEN, CfgDataW'($urandom_range(1, 64)));
    write_reg(REG_COV_CAP, CfgDataW'($urandom_range(0, 65535)));
    random_runs(80);
    write_reg(REG_SEG_LEN, 21'd1024);
    write_reg(REG_COV_CAP, 21'd250);
    random_runs(80);
    write_reg(REG_SEG_LEN, CfgDataW'($urandom_range(1, 1048576)));
    write_reg(REG_COV_CAP, 21'hFFFF);
    random_runs(60);
    write_reg(REG_SEG_LEN, 21'd0);
    write_reg(REG_COV_CAP, CfgDataW'($urandom_range(0, 300)));
    random_runs(60);
  endtask

  // long output stall while runs keep coming
  task automatic test_backpressure();
    write_reg(REG_SEG_LEN, CfgDataW'($urandom_range(1, 32)));
    write_reg(REG_COV_CAP, CfgDataW'($urandom_range(100, 400)));
    hold_req = 1'b1;
    random_runs(80);
  endtask

  // no idling on either side
  task automatic test_full_rate();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_reg(REG_SEG_LEN, CfgDataW'($urandom_range(1, 256)));
    write_reg(REG_COV_CAP, CfgDataW'($urandom_range(0, 65535)));
    random_runs(120);
  endtask

  // output side: random stall bursts and one long hold
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [ValW-1:0] want,
                                      input logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // compare each output beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    window_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected result beat: kind %0d value %0d", m_axis_tuser,
               m_axis_tdata[ValW-1:0]);
        fail_count++;
      end else begin
        want = expected_bins.pop_front();
        check_field("kind", ValW'(want.kind), ValW'(m_axis_tuser));
        check_field("value", want.value, m_axis_tdata[ValW-1:0]);
        check_field("repeat_res", want.reps, m_axis_tdata[ValW+RepW-1:ValW]);
        check_field("last", ValW'(want.last), ValW'(m_axis_tlast));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_windows();
    test_extreme_settings();
    test_shrunk_window();
    test_merging_and_overlap();
    test_random_contigs();
    test_backpressure();
    test_full_rate();
    if (fail_count == 0 && expected_bins.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
